@@ rtl/interval_timer_three_channel_assert.svh @@
// Assertion macros for the interval timer.
// Used by the top level only; depends on nothing else.
`ifndef INTERVAL_TIMER_THREE_CHANNEL_ASSERT_SVH
`define INTERVAL_TIMER_THREE_CHANNEL_ASSERT_SVH

// same-cycle implication
`define IVT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ivt_pkg.sv @@
// Shared types and codes for the interval timer.
// No dependencies.
package ivt_pkg;

    localparam int NUM_CHANNELS_DEF = 3;
    localparam int COUNT_BITS_DEF   = 16;
    localparam int TICK_BITS        = 16;

    localparam logic       FUNC_TICK      = 1'b1;
    localparam logic [1:0] PORT_CTRL      = 2'd3;
    localparam logic [1:0] CH_READBACK    = 2'd3;
    localparam logic [1:0] ACCESS_LATCH   = 2'd0;
    localparam logic [1:0] ACCESS_LSB_MSB = 2'd3;
    localparam logic [2:0] MODE_RATE      = 3'd2;

    localparam logic [1:0] IRQ_NONE  = 2'd0;
    localparam logic [1:0] IRQ_RAISE = 2'd1;
    localparam logic [1:0] IRQ_PULSE = 2'd2;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_READBACK = 3'd1;
    localparam logic [2:0] ERR_LATCH    = 3'd2;
    localparam logic [2:0] ERR_BCD      = 3'd3;
    localparam logic [2:0] ERR_ACCESS   = 3'd4;

    typedef struct packed {
        logic [1:0]           irq_event;
        logic [2:0]           error;
        logic                 running;
        logic [TICK_BITS-1:0] ticks_to_next;
    } t_result;

endpackage

@@ rtl/ivt_core.sv @@
// Timer state registers and the single-pass update for one transaction.
// Depends on ivt_pkg.
module ivt_core #(
    parameter int NUM_CHANNELS = ivt_pkg::NUM_CHANNELS_DEF,
    parameter int COUNT_BITS   = ivt_pkg::COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  logic             i_func,
    input  logic [1:0]       i_port,
    input  logic [7:0]       i_data,
    output ivt_pkg::t_result o_res
);
    import ivt_pkg::*;

    localparam int         CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [2:0] NCH  = 3'(NUM_CHANNELS);

    logic [COUNT_BITS-1:0] r_count  [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] n_count  [NUM_CHANNELS];
    logic [1:0]            r_access [NUM_CHANNELS];
    logic [1:0]            n_access [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_lbd, n_lbd;
    logic [NUM_CHANNELS-1:0] r_run, n_run;
    logic [TICK_BITS-1:0]  r_elapsed, n_elapsed;

    logic [1:0]            ctl_ch, ctl_acc;
    logic [2:0]            ctl_mode;
    logic [CH_W-1:0]       ctl_idx, cnt_idx;
    logic [TICK_BITS-1:0]  inc, cnt0;

    assign ctl_ch   = i_data[7:6];
    assign ctl_acc  = i_data[5:4];
    assign ctl_mode = i_data[3:1];
    assign ctl_idx  = ctl_ch[CH_W-1:0];
    assign cnt_idx  = i_port[CH_W-1:0];
    assign inc      = (r_elapsed == {TICK_BITS{1'b1}}) ? r_elapsed : r_elapsed + 1'b1;

    always_comb begin
        n_count   = r_count;
        n_access  = r_access;
        n_lbd     = r_lbd;
        n_run     = r_run;
        n_elapsed = r_elapsed;
        o_res.irq_event = IRQ_NONE;
        o_res.error     = ERR_OK;
        if (i_func == FUNC_TICK) begin
            if (r_run[0]) begin
                if (inc >= TICK_BITS'(r_count[0])) begin
                    n_elapsed = '0;
                    o_res.irq_event = IRQ_PULSE;
                end else begin
                    n_elapsed = inc;
                end
            end
        end else if (i_port == PORT_CTRL) begin
            if (ctl_ch == CH_READBACK) begin
                o_res.error = ERR_READBACK;
            end else if (ctl_acc == ACCESS_LATCH) begin
                o_res.error = ERR_LATCH;
            end else if (i_data[0]) begin
                o_res.error = ERR_BCD;
            end else if ({1'b0, ctl_ch} < NCH) begin
                n_access[ctl_idx] = ctl_acc;
                if (ctl_mode == MODE_RATE && ctl_ch == 2'd0) begin
                    o_res.irq_event = IRQ_RAISE;
                end
            end
        end else if ({1'b0, i_port} < NCH) begin
            if (r_access[cnt_idx] != ACCESS_LSB_MSB) begin
                o_res.error = ERR_ACCESS;
            end else if (r_lbd[cnt_idx]) begin
                n_count[cnt_idx] = COUNT_BITS'({i_data, 8'h00} | 16'(r_count[cnt_idx]));
                n_run[cnt_idx]   = 1'b1;
                n_lbd[cnt_idx]   = 1'b0;
                if (i_port == 2'd0) begin
                    n_elapsed = '0;
                end
            end else begin
                n_count[cnt_idx] = COUNT_BITS'(i_data);
                n_lbd[cnt_idx]   = 1'b1;
            end
        end
        cnt0          = TICK_BITS'(n_count[0]);
        o_res.running = n_run[0];
        o_res.ticks_to_next = (n_run[0] && n_elapsed < cnt0) ? cnt0 - n_elapsed : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_count[k]  <= '0;
                r_access[k] <= '0;
            end
            r_lbd     <= '0;
            r_run     <= '0;
            r_elapsed <= '0;
        end else if (i_acc) begin
            r_count   <= n_count;
            r_access  <= n_access;
            r_lbd     <= n_lbd;
            r_run     <= n_run;
            r_elapsed <= n_elapsed;
        end
    end

endmodule

@@ rtl/ivt_obuf.sv @@
// Result register between the timer core and the output channel.
// Depends on ivt_pkg.
module ivt_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  ivt_pkg::t_result i_res,
    input  logic             i_out_stall,
    output logic             o_valid,
    output ivt_pkg::t_result o_res
);
    import ivt_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_acc) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ rtl/interval_timer_three_channel.sv @@
// Top level of the three-channel interval timer: core plus result register.
// Depends on ivt_pkg, ivt_core, ivt_obuf and the assertion macro header.
//
//  channel | direction | handshake                  | payload
//  in      | to block  | i_in_valid / o_in_stall    | i_func, i_port, i_data
//  out     | from block| o_out_valid / i_out_stall  | o_irq_event, o_error,
//          |           |                            | o_running, o_ticks_to_next
//
// One transaction per clock unless stalled; result valid the next cycle.
// The input stalls only while a result is held and the output is stalled.
// Synchronous active-low reset clears all timer state and the result valid.
// All updates are a single pass through the core between register stages.
`include "interval_timer_three_channel_assert.svh"
module interval_timer_three_channel #(
    parameter int NUM_CHANNELS = ivt_pkg::NUM_CHANNELS_DEF,
    parameter int COUNT_BITS   = ivt_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [1:0]  i_port,
    input  logic [7:0]  i_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_irq_event,
    output logic [2:0]  o_error,
    output logic        o_running,
    output logic [15:0] o_ticks_to_next
);
    import ivt_pkg::*;

    logic    in_acc;
    t_result core_res, out_res;

    assign o_in_stall = o_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;

    ivt_core #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_acc  (in_acc),
        .i_func (i_func),
        .i_port (i_port),
        .i_data (i_data),
        .o_res  (core_res)
    );

    ivt_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (in_acc),
        .i_res      (core_res),
        .i_out_stall(i_out_stall),
        .o_valid    (o_out_valid),
        .o_res      (out_res)
    );

    assign o_irq_event     = out_res.irq_event;
    assign o_error         = out_res.error;
    assign o_running       = out_res.running;
    assign o_ticks_to_next = out_res.ticks_to_next;

    `IVT_ASSERT_NEXT(a_acc_gives_result, i_clk, i_rst_n, in_acc, o_out_valid, "accepted transaction produced no result")
    `IVT_ASSERT_NOW(a_pulse_running, i_clk, i_rst_n, o_out_valid && o_irq_event == IRQ_PULSE, o_running, "pulse while channel 0 stopped")
    `IVT_ASSERT_NOW(a_err_no_irq, i_clk, i_rst_n, o_out_valid && o_error != ERR_OK, o_irq_event == IRQ_NONE, "interrupt event on rejected write")
    `IVT_ASSERT_NOW(a_idle_no_ticks, i_clk, i_rst_n, o_out_valid && !o_running, o_ticks_to_next == '0, "ticks left while stopped")

endmodule
